// ===== design/msd_pkg.sv =====
// Shared constants and types for the Morse symbol stream decoder.
package msd_pkg;

    localparam int DEF_TABLE_DEPTH  = 32;
    localparam int DEF_MAX_CODE_LEN = 4;

    localparam int LETTER_W    = 8;
    localparam int INDEX_W     = 5;
    localparam int ENT_LEN_W   = 3;
    localparam int ENT_PAT_W   = 4;
    localparam int LIMIT_W     = 6;
    localparam int CMP_LEN_W   = 4;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    localparam logic [LETTER_W-1:0] CHAR_UNKNOWN = 8'h3F;
    localparam logic [LETTER_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [LETTER_W-1:0] CHAR_DOT     = 8'h2E;
    localparam logic [LETTER_W-1:0] CHAR_DASH    = 8'h2D;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_ENTRIES_IN_USE = 1'b0;

    typedef struct packed {
        logic valid;
        logic invalid;
        logic found;
        logic word_end;
    } t_flags;

endpackage

// ===== design/msd_accum.sv =====
// Letter accumulator: collects dots and dashes and launches a search token on close.
module msd_accum
    import msd_pkg::*;
#(
    parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN,
    parameter int LEN_W        = $clog2(MAX_CODE_LEN + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_take,
    input  logic [LETTER_W-1:0]     i_symbol,
    input  logic                    i_word_end,
    output t_flags                  o_flags,
    output logic [LEN_W-1:0]        o_len,
    output logic [MAX_CODE_LEN-1:0] o_pat
);

    logic [LEN_W-1:0]        r_len, n_len;
    logic [MAX_CODE_LEN-1:0] r_pat, n_pat;
    logic                    r_inv, n_inv;

    logic                    is_dot, is_dash, do_app, closing;
    logic [LEN_W-1:0]        a_len;
    logic [MAX_CODE_LEN-1:0] a_pat;
    logic                    a_inv;

    assign is_dot  = (i_symbol == CHAR_DOT);
    assign is_dash = (i_symbol == CHAR_DASH);
    assign closing = i_word_end || (i_symbol == CHAR_SPACE);
    // a last-of-word character is appended even when it is a space
    assign do_app  = i_word_end || (i_symbol != CHAR_SPACE);

    always_comb begin
        a_len = r_len;
        a_pat = r_pat;
        a_inv = r_inv;
        if (do_app && !r_inv) begin
            if ((int'(r_len) >= MAX_CODE_LEN) || !(is_dot || is_dash)) begin
                a_inv = 1'b1;
            end else begin
                for (int b = 0; b < MAX_CODE_LEN; b++) begin
                    if (is_dash && (b == int'(r_len))) begin
                        a_pat[b] = 1'b1;
                    end
                end
                a_len = r_len + LEN_W'(1);
            end
        end
    end

    always_comb begin
        n_len = r_len;
        n_pat = r_pat;
        n_inv = r_inv;
        if (i_take) begin
            if (closing) begin
                n_len = '0;
                n_pat = '0;
                n_inv = 1'b0;
            end else begin
                n_len = a_len;
                n_pat = a_pat;
                n_inv = a_inv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_pat <= '0;
            r_inv <= 1'b0;
        end else begin
            r_len <= n_len;
            r_pat <= n_pat;
            r_inv <= n_inv;
        end
    end

    always_comb begin
        o_flags.valid    = i_take && closing;
        o_flags.invalid  = a_inv;
        o_flags.found    = 1'b0;
        o_flags.word_end = i_word_end;
        o_len            = a_len;
        o_pat            = a_pat;
    end

endmodule

// ===== design/msd_cell.sv =====
// One table slot: holds an entry and checks the passing search token against it.
module msd_cell
    import msd_pkg::*;
#(
    parameter int CELL_INDEX   = 0,
    parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN,
    parameter int LEN_W        = $clog2(MAX_CODE_LEN + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_ld,
    input  logic [INDEX_W-1:0]      i_ld_index,
    input  logic [LETTER_W-1:0]     i_ld_letter,
    input  logic [ENT_LEN_W-1:0]    i_ld_length,
    input  logic [ENT_PAT_W-1:0]    i_ld_pattern,
    input  logic [LIMIT_W-1:0]      i_limit,
    input  t_flags                  i_flags,
    input  logic [LEN_W-1:0]        i_len,
    input  logic [MAX_CODE_LEN-1:0] i_pat,
    input  logic [LETTER_W-1:0]     i_letter,
    output t_flags                  o_flags,
    output logic [LEN_W-1:0]        o_len,
    output logic [MAX_CODE_LEN-1:0] o_pat,
    output logic [LETTER_W-1:0]     o_letter
);

    localparam int PAT_W = (MAX_CODE_LEN > ENT_PAT_W) ? MAX_CODE_LEN : ENT_PAT_W;

    logic [LETTER_W-1:0]     r_letter;
    logic [ENT_LEN_W-1:0]    r_length;
    logic [ENT_PAT_W-1:0]    r_pattern;

    t_flags                  r_tok_flags, n_tok_flags;
    logic [LEN_W-1:0]        r_tok_len;
    logic [MAX_CODE_LEN-1:0] r_tok_pat;
    logic [LETTER_W-1:0]     r_tok_letter, n_tok_letter;

    logic                    wr, active, hit;
    logic [PAT_W-1:0]        mask, ent_pat, acc_pat;

    assign wr     = i_ld && (int'(i_ld_index) == CELL_INDEX);
    assign active = (CELL_INDEX < int'(i_limit));

    assign ent_pat = PAT_W'(r_pattern);
    assign acc_pat = PAT_W'(i_pat);

    always_comb begin
        for (int b = 0; b < PAT_W; b++) begin
            mask[b] = (b < int'(i_len));
        end
    end

    assign hit = active && i_flags.valid && !i_flags.invalid && !i_flags.found
              && (int'(r_length) <= MAX_CODE_LEN)
              && (CMP_LEN_W'(r_length) == CMP_LEN_W'(i_len))
              && ((ent_pat & mask) == acc_pat);

    always_comb begin
        n_tok_flags       = i_flags;
        n_tok_flags.found = i_flags.found || hit;
        n_tok_letter      = hit ? r_letter : i_letter;
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_letter  <= i_ld_letter;
            r_length  <= i_ld_length;
            r_pattern <= i_ld_pattern;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_flags <= '0;
        end else if (i_en) begin
            r_tok_flags <= n_tok_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tok_len    <= i_len;
            r_tok_pat    <= i_pat;
            r_tok_letter <= n_tok_letter;
        end
    end

    assign o_flags  = r_tok_flags;
    assign o_len    = r_tok_len;
    assign o_pat    = r_tok_pat;
    assign o_letter = r_tok_letter;

endmodule

// ===== design/morse_symbol_stream_decoder.sv =====
// Morse symbol stream decoder top level: accumulator, slot chain and output register.
//
// Load items write one slot of a TABLE_DEPTH-long chain of cells. Decode
// items that do not close a letter update the accumulator and do not stall the
// input. A closing item (space, or last character of a word) launches a search
// token that moves one cell per clock down the chain while the chain is not
// held. No further item is taken until the result at the end of the chain is
// loaded into the output register; the chain holds while a finished result is
// not taken.
// The first in-use slot whose code matches gives the letter, else '?' with
// o_unknown set. entries_in_use sits at APB byte address 0; the user must
// write it only while the block is idle, and the block itself does not
// enforce this.
module morse_symbol_stream_decoder
    import msd_pkg::*;
#(
    parameter int TABLE_DEPTH  = DEF_TABLE_DEPTH,
    parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_opcode,
    input  logic [INDEX_W-1:0]    i_entry_index,
    input  logic [LETTER_W-1:0]   i_entry_letter,
    input  logic [ENT_LEN_W-1:0]  i_entry_length,
    input  logic [ENT_PAT_W-1:0]  i_entry_pattern,
    input  logic [LETTER_W-1:0]   i_symbol,
    input  logic                  i_word_end,

    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [LETTER_W-1:0]   o_letter,
    output logic                  o_unknown,
    output logic                  o_last_of_word,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);

    logic [LIMIT_W-1:0]      r_limit;
    logic                    r_busy, n_busy;
    logic                    r_out_valid, n_out_valid;
    logic [LETTER_W-1:0]     r_letter;
    logic                    r_unknown, r_last;

    logic                    accept, take, ld, en, load_out;

    t_flags                  st_flags  [TABLE_DEPTH+1];
    logic [LEN_W-1:0]        st_len    [TABLE_DEPTH+1];
    logic [MAX_CODE_LEN-1:0] st_pat    [TABLE_DEPTH+1];
    logic [LETTER_W-1:0]     st_letter [TABLE_DEPTH+1];

    assign o_ready = !r_busy;
    assign accept  = i_valid && o_ready;
    assign take    = accept && (i_opcode == OP_DECODE);
    assign ld      = accept && (i_opcode == OP_LOAD);

    // chain holds only when a result is at the end and the output is full and not being taken
    assign en       = !(st_flags[TABLE_DEPTH].valid && r_out_valid && !i_ready);
    assign load_out = st_flags[TABLE_DEPTH].valid && en;

    msd_accum #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .LEN_W        (LEN_W)
    ) u_accum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_symbol   (i_symbol),
        .i_word_end (i_word_end),
        .o_flags    (st_flags[0]),
        .o_len      (st_len[0]),
        .o_pat      (st_pat[0])
    );

    assign st_letter[0] = CHAR_UNKNOWN;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        msd_cell #(
            .CELL_INDEX   (g),
            .MAX_CODE_LEN (MAX_CODE_LEN),
            .LEN_W        (LEN_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_en         (en),
            .i_ld         (ld),
            .i_ld_index   (i_entry_index),
            .i_ld_letter  (i_entry_letter),
            .i_ld_length  (i_entry_length),
            .i_ld_pattern (i_entry_pattern),
            .i_limit      (r_limit),
            .i_flags      (st_flags[g]),
            .i_len        (st_len[g]),
            .i_pat        (st_pat[g]),
            .i_letter     (st_letter[g]),
            .o_flags      (st_flags[g+1]),
            .o_len        (st_len[g+1]),
            .o_pat        (st_pat[g+1]),
            .o_letter     (st_letter[g+1])
        );
    end

    always_comb begin
        n_busy = r_busy;
        if (st_flags[0].valid) begin
            n_busy = 1'b1;
        end else if (load_out) begin
            n_busy = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_limit     <= '0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
            if (psel && penable && pwrite && (paddr[2] == REG_ENTRIES_IN_USE)) begin
                r_limit <= pwdata[LIMIT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_letter  <= st_letter[TABLE_DEPTH];
            r_unknown <= !st_flags[TABLE_DEPTH].found;
            r_last    <= st_flags[TABLE_DEPTH].word_end;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_letter       = r_letter;
    assign o_unknown      = r_unknown;
    assign o_last_of_word = r_last;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ENTRIES_IN_USE) ? APB_DATA_W'(r_limit) : '0;

endmodule
